>>> design/eq2q_pkg.sv
`default_nettype none

package eq2q_pkg;

  // CORDIC datapath format: x, y with 30 fractional bits, z in 2^-24 degree
  localparam int CordicFrac  = 30;
  localparam int CordicWidth = 32;
  localparam logic [CordicWidth-1:0] CordicX0 = 32'd652032874;

  // Half angle fold limits, 1/256 degree
  localparam logic signed [16:0] QuarterTurn = 17'sd23040;
  localparam logic signed [16:0] HalfTurn    = 17'sd46080;

  // One CORDIC lane set: roll, pitch, yaw (index 0, 1, 2)
  typedef struct packed {
    logic [2:0][CordicWidth-1:0] x;
    logic [2:0][CordicWidth-1:0] y;
    logic [2:0][CordicWidth-1:0] z;
    logic [2:0]                  neg;
  } cordic_lanes_t;

  // atan(2^-i) in units of 2^-24 degree
  function automatic logic [CordicWidth-1:0] atan_entry(input logic [4:0] idx);
    logic [CordicWidth-1:0] v;
    case (idx)
      5'd0:    v = 32'd754974720;
      5'd1:    v = 32'd445687602;
      5'd2:    v = 32'd235489088;
      5'd3:    v = 32'd119537938;
      5'd4:    v = 32'd60000934;
      5'd5:    v = 32'd30029717;
      5'd6:    v = 32'd15018523;
      5'd7:    v = 32'd7509720;
      5'd8:    v = 32'd3754917;
      5'd9:    v = 32'd1877466;
      5'd10:   v = 32'd938734;
      5'd11:   v = 32'd469367;
      5'd12:   v = 32'd234684;
      5'd13:   v = 32'd117342;
      5'd14:   v = 32'd58671;
      5'd15:   v = 32'd29335;
      5'd16:   v = 32'd14668;
      5'd17:   v = 32'd7334;
      5'd18:   v = 32'd3667;
      5'd19:   v = 32'd1833;
      5'd20:   v = 32'd917;
      5'd21:   v = 32'd458;
      5'd22:   v = 32'd229;
      5'd23:   v = 32'd115;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> design/eq2q_fold.sv
`default_nettype none

module eq2q_fold
  import eq2q_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [47:0]   in_data,   // roll, pitch, yaw from bit 0 up
  output logic               out_valid,
  input  wire logic          out_ready,
  output cordic_lanes_t      out_data
);

  logic          vld;
  cordic_lanes_t lanes;
  cordic_lanes_t lanes_next;
  logic          adv;

  assign adv      = !vld || out_ready;
  assign in_ready = adv;

  // Fold each half angle into +-90 degrees and seed the rotation
  always_comb begin
    logic signed [16:0] a;
    logic signed [16:0] af;
    lanes_next = '0;
    for (int k = 0; k < 3; k++) begin
      a  = 17'($signed(in_data[16*k +: 16]));
      af = a;
      lanes_next.neg[k] = 1'b0;
      if (a > QuarterTurn) begin
        af = a - HalfTurn;
        lanes_next.neg[k] = 1'b1;
      end else if (a < -QuarterTurn) begin
        af = a + HalfTurn;
        lanes_next.neg[k] = 1'b1;
      end
      lanes_next.x[k] = CordicX0;
      lanes_next.y[k] = '0;
      lanes_next.z[k] = {af[15:0], 16'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      lanes <= lanes_next;
    end
  end

  assign out_valid = vld;
  assign out_data  = lanes;

endmodule

`default_nettype wire

>>> design/eq2q_cordic_stage.sv
`default_nettype none

module eq2q_cordic_stage
  import eq2q_pkg::*;
#(
  parameter int STEP = 0
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire cordic_lanes_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output cordic_lanes_t      out_data
);

  localparam logic [CordicWidth-1:0] Atan = atan_entry(5'(STEP));

  logic          vld;
  cordic_lanes_t lanes;
  cordic_lanes_t lanes_next;
  logic          adv;

  assign adv      = !vld || out_ready;
  assign in_ready = adv;

  // One micro-rotation on all three lanes, direction from the sign of z
  always_comb begin
    logic signed [CordicWidth-1:0] dx;
    logic signed [CordicWidth-1:0] dy;
    lanes_next = in_data;
    for (int k = 0; k < 3; k++) begin
      dx = $signed(in_data.y[k]) >>> STEP;
      dy = $signed(in_data.x[k]) >>> STEP;
      if (!in_data.z[k][CordicWidth-1]) begin
        lanes_next.x[k] = in_data.x[k] - dx;
        lanes_next.y[k] = in_data.y[k] + dy;
        lanes_next.z[k] = in_data.z[k] - Atan;
      end else begin
        lanes_next.x[k] = in_data.x[k] + dx;
        lanes_next.y[k] = in_data.y[k] - dy;
        lanes_next.z[k] = in_data.z[k] + Atan;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      lanes <= lanes_next;
    end
  end

  assign out_valid = vld;
  assign out_data  = lanes;

endmodule

`default_nettype wire

>>> design/eq2q_quat.sv
`default_nettype none

module eq2q_quat
  import eq2q_pkg::*;
#(
  parameter int QUAT_FRAC_BITS = 14
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire cordic_lanes_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [63:0]        out_data   // quat_w, quat_x, quat_y, quat_z from bit 0 up
);

  localparam int QW = QUAT_FRAC_BITS + 2;          // trig / product width
  localparam int PW = 2 * QW;                      // raw product width
  localparam int SW = (QW + 1 > 16) ? QW + 1 : 16; // sum width before truncation
  localparam int RS = CordicFrac - QUAT_FRAC_BITS; // trig rounding shift
  localparam logic signed [PW-1:0] MulHalf = PW'(1) <<< (QUAT_FRAC_BITS - 1);
  localparam logic signed [QW:0]   One     = (QW+1)'(1) <<< QUAT_FRAC_BITS;

  // stage valids and advance enables
  logic v_trig, v_m1, v_m2, v_out;
  logic a_trig, a_m1, a_m2, a_out;

  assign a_out    = !v_out  || out_ready;
  assign a_m2     = !v_m2   || a_out;
  assign a_m1     = !v_m1   || a_m2;
  assign a_trig   = !v_trig || a_m1;
  assign in_ready = a_trig;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_trig <= 1'b0;
      v_m1   <= 1'b0;
      v_m2   <= 1'b0;
      v_out  <= 1'b0;
    end else begin
      if (a_trig) v_trig <= in_valid;
      if (a_m1)   v_m1   <= v_trig;
      if (a_m2)   v_m2   <= v_m1;
      if (a_out)  v_out  <= v_m2;
    end
  end

  // Stage 1: round CORDIC outputs to QUAT_FRAC_BITS and apply fold sign
  logic signed [QW-1:0] cos_next [3];
  logic signed [QW-1:0] sin_next [3];
  logic signed [QW-1:0] cos_r [3];
  logic signed [QW-1:0] sin_r [3];

  for (genvar k = 0; k < 3; k++) begin : g_trig
    logic signed [CordicWidth-1:0] xr;
    logic signed [CordicWidth-1:0] yr;
    if (RS > 0) begin : g_rnd
      localparam logic signed [CordicWidth-1:0] TrigHalf = CordicWidth'(1) <<< (RS - 1);
      assign xr = ($signed(in_data.x[k]) + TrigHalf) >>> RS;
      assign yr = ($signed(in_data.y[k]) + TrigHalf) >>> RS;
    end else begin : g_pass
      assign xr = $signed(in_data.x[k]);
      assign yr = $signed(in_data.y[k]);
    end
    always_comb begin
      logic signed [CordicWidth-1:0] xs;
      logic signed [CordicWidth-1:0] ys;
      xs = in_data.neg[k] ? -xr : xr;
      ys = in_data.neg[k] ? -yr : yr;
      cos_next[k] = xs[QW-1:0];
      sin_next[k] = ys[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (a_trig && in_valid) begin
      cos_r <= cos_next;
      sin_r <= sin_next;
    end
  end

  // Rounded fixed-point product
  function automatic logic signed [QW-1:0] fmul(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
    logic signed [PW-1:0] p;
    p = (PW'(a) * PW'(b) + MulHalf) >>> QUAT_FRAC_BITS;
    return p[QW-1:0];
  endfunction

  // Stage 2: roll x pitch products, yaw terms carried along
  logic signed [QW-1:0] rp_cc, rp_ss, rp_sc, rp_cs;
  logic signed [QW-1:0] cy_m1, sy_m1;

  always_ff @(posedge clk) begin
    if (a_m1 && v_trig) begin
      rp_cc <= fmul(cos_r[0], cos_r[1]);
      rp_ss <= fmul(sin_r[0], sin_r[1]);
      rp_sc <= fmul(sin_r[0], cos_r[1]);
      rp_cs <= fmul(cos_r[0], sin_r[1]);
      cy_m1 <= cos_r[2];
      sy_m1 <= sin_r[2];
    end
  end

  // Stage 3: the eight triple products
  logic signed [QW-1:0] t_cccy, t_sssy, t_sccy, t_cssy;
  logic signed [QW-1:0] t_cscy, t_scsy, t_ccsy, t_sscy;

  always_ff @(posedge clk) begin
    if (a_m2 && v_m1) begin
      t_cccy <= fmul(rp_cc, cy_m1);
      t_sssy <= fmul(rp_ss, sy_m1);
      t_sccy <= fmul(rp_sc, cy_m1);
      t_cssy <= fmul(rp_cs, sy_m1);
      t_cscy <= fmul(rp_cs, cy_m1);
      t_scsy <= fmul(rp_sc, sy_m1);
      t_ccsy <= fmul(rp_cc, sy_m1);
      t_sscy <= fmul(rp_ss, cy_m1);
    end
  end

  // Clamp to +-1.0 and keep the low 16 bits
  function automatic logic [15:0] sat_out(input logic signed [QW:0] v);
    logic signed [QW:0]   c;
    logic signed [SW-1:0] e;
    c = v;
    if (v > One)  c = One;
    if (v < -One) c = -One;
    e = SW'(c);
    return e[15:0];
  endfunction

  // Stage 4: combine, saturate, output register
  logic [63:0] quat;

  always_ff @(posedge clk) begin
    if (a_out && v_m2) begin
      quat[15:0]  <= sat_out((QW+1)'(t_cccy) + (QW+1)'(t_sssy));
      quat[31:16] <= sat_out((QW+1)'(t_sccy) - (QW+1)'(t_cssy));
      quat[47:32] <= sat_out((QW+1)'(t_cscy) + (QW+1)'(t_scsy));
      quat[63:48] <= sat_out((QW+1)'(t_ccsy) - (QW+1)'(t_sscy));
    end
  end

  assign out_valid = v_out;
  assign out_data  = quat;

endmodule

`default_nettype wire

>>> design/euler_zyx_to_quaternion_top.sv
// Channel   Dir  tdata (bit 0 up)                       Width
// s_axis    in   roll_angle, pitch_angle, yaw_angle     48
// m_axis    out  quat_w, quat_x, quat_y, quat_z         64
//
// One fold stage, one register per CORDIC micro-rotation, then round, two
// multiply stages and the sum stage. One pose per cycle is accepted while
// s_axis_tready is high; each stage moves on its own when the next one has
// room, so a stalled output fills bubbles before back-pressure reaches
// s_axis_tready. rst (synchronous) clears all valid bits.
`default_nettype none

module euler_zyx_to_quaternion_top
  import eq2q_pkg::*;
#(
  parameter int TRIG_ITERATIONS = 14,
  parameter int QUAT_FRAC_BITS  = 14
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // roll_angle, pitch_angle, yaw_angle
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata    // quat_w, quat_x, quat_y, quat_z
);

  logic          st_valid [TRIG_ITERATIONS+1];
  logic          st_ready [TRIG_ITERATIONS+1];
  cordic_lanes_t st_data  [TRIG_ITERATIONS+1];

  // Angle fold and CORDIC seed
  eq2q_fold u_fold (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .out_valid (st_valid[0]),
    .out_ready (st_ready[0]),
    .out_data  (st_data[0])
  );

  // Unrolled CORDIC, one register stage per micro-rotation
  for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_cordic
    eq2q_cordic_stage #(
      .STEP (i)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (st_valid[i]),
      .in_ready  (st_ready[i]),
      .in_data   (st_data[i]),
      .out_valid (st_valid[i+1]),
      .out_ready (st_ready[i+1]),
      .out_data  (st_data[i+1])
    );
  end

  // Rounding, products and saturation
  eq2q_quat #(
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_quat (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (st_valid[TRIG_ITERATIONS]),
    .in_ready  (st_ready[TRIG_ITERATIONS]),
    .in_data   (st_data[TRIG_ITERATIONS]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

`default_nettype wire

>>> design/eq2q_checker.sv
`default_nettype none

module eq2q_checker #(
  parameter int DEPTH = 19
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [63:0] m_axis_tdata
);

  localparam int CW = $clog2(DEPTH + 2);

  logic          in_xfer;
  logic          out_xfer;
  logic [CW-1:0] pending;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  // Poses inside the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + CW'(in_xfer) - CW'(out_xfer);
    end
  end

  // Pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // No result without a pose behind it
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> pending != '0)
    else $error("result with no pose in flight");

  // Never more poses in flight than stages
  a_capacity: assert property (@(posedge clk) disable iff (rst)
    pending <= CW'(DEPTH))
    else $error("pipeline holds more poses than stages");

  // Empty pipeline always takes input
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    pending == '0 |-> s_axis_tready)
    else $error("empty pipeline refused input");

endmodule

bind euler_zyx_to_quaternion_top eq2q_checker #(
  .DEPTH (TRIG_ITERATIONS + 5)
) u_eq2q_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
